/* rtl/glyph_framebuffer_renderer_defines.svh */
// assertion macros for the glyph framebuffer renderer
`ifndef GLYPH_FRAMEBUFFER_RENDERER_DEFINES_SVH
`define GLYPH_FRAMEBUFFER_RENDERER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define GFR_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glyph renderer check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define GFR_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glyph renderer check failed");

`endif

/* rtl/gfr_pkg.sv */
// types, constants and font tables of the glyph framebuffer renderer
`timescale 1ns / 1ps

package gfr_pkg;

	localparam int GRID_W  = 8;
	localparam int GRID_H  = 16;
	localparam int CELLS   = GRID_W * GRID_H;
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int COL_W   = $clog2(GRID_W);
	localparam int ROW_W   = $clog2(GRID_H);
	localparam int COLOR_W = 24;
	localparam int COUNT_W = 8;
	localparam int COORD_W = 6;
	localparam int SIZE_W  = 5;
	localparam int DIG_W   = 4;
	localparam int DIG_H   = 6;
	localparam int LET_W   = 5;
	localparam int LET_H   = 5;
	localparam int N_DIG   = 10;
	localparam int N_LET   = 26;

	typedef enum logic [1:0] {
		OP_CHAR   = 2'd0,
		OP_SQUARE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ROT_NONE = 2'd0,
		ROT_90   = 2'd1,
		ROT_180  = 2'd2,
		ROT_270  = 2'd3
	} rot_t;

	typedef enum logic [1:0] {
		GLY_NONE   = 2'd0,
		GLY_DIGIT  = 2'd1,
		GLY_LETTER = 2'd2
	} glyph_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_GLYPH,
		ST_SQUARE,
		ST_CLEAR,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic glyph_step;
		logic square_step;
		logic clear;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		op_t         op;
		glyph_kind_t kind;
		logic        size_zero;
		logic        last_cell;
	} sts_t;

	// rows top to bottom, leftmost column in the top bit
	localparam logic [DIG_W-1:0] DIGIT_ROM [N_DIG][DIG_H] = '{
		'{4'h6, 4'h9, 4'h9, 4'h9, 4'h9, 4'h6}, '{4'h2, 4'h6, 4'hA, 4'h2, 4'h2, 4'hF},
		'{4'h6, 4'h9, 4'h1, 4'h2, 4'h4, 4'hF}, '{4'hE, 4'h1, 4'h2, 4'h1, 4'h9, 4'h6},
		'{4'h2, 4'h6, 4'hA, 4'hF, 4'h2, 4'h2}, '{4'hF, 4'h8, 4'hE, 4'h1, 4'h9, 4'h6},
		'{4'h6, 4'h9, 4'h8, 4'hE, 4'h9, 4'h6}, '{4'hF, 4'h1, 4'h2, 4'h4, 4'h4, 4'h4},
		'{4'h6, 4'h9, 4'h6, 4'h9, 4'h9, 4'h6}, '{4'h6, 4'h9, 4'h9, 4'h7, 4'h1, 4'h6}
	};

	localparam logic [LET_W-1:0] LETTER_ROM [N_LET][LET_H] = '{
		'{5'h0E, 5'h11, 5'h1F, 5'h11, 5'h11}, '{5'h1E, 5'h11, 5'h1F, 5'h11, 5'h1E},
		'{5'h0E, 5'h11, 5'h10, 5'h11, 5'h0E}, '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E},
		'{5'h1F, 5'h10, 5'h1E, 5'h10, 5'h1F}, '{5'h1F, 5'h10, 5'h1E, 5'h10, 5'h10},
		'{5'h0E, 5'h10, 5'h13, 5'h11, 5'h0E}, '{5'h11, 5'h11, 5'h1F, 5'h11, 5'h11},
		'{5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F}, '{5'h03, 5'h01, 5'h01, 5'h11, 5'h0E},
		'{5'h12, 5'h14, 5'h18, 5'h18, 5'h16}, '{5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
		'{5'h11, 5'h1B, 5'h15, 5'h11, 5'h11}, '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11},
		'{5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E}, '{5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10},
		'{5'h0E, 5'h11, 5'h15, 5'h13, 5'h0F}, '{5'h1E, 5'h11, 5'h1E, 5'h12, 5'h11},
		'{5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E}, '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04},
		'{5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, '{5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
		'{5'h11, 5'h11, 5'h15, 5'h1B, 5'h11}, '{5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11},
		'{5'h11, 5'h0A, 5'h04, 5'h04, 5'h04}, '{5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F}
	};

	// one font row, right aligned; zero for anything out of the tables
	function automatic logic [LET_W-1:0] font_row(glyph_kind_t kind, logic [4:0] sym,
			logic [2:0] r);
		logic [LET_W-1:0] row;
		row = '0;
		if (kind == GLY_DIGIT && sym < 5'(N_DIG) && r < 3'(DIG_H))
			row = {1'b0, DIGIT_ROM[sym[3:0]][r]};
		else if (kind == GLY_LETTER && sym < 5'(N_LET) && r < 3'(LET_H))
			row = LETTER_ROM[sym][r];
		return row;
	endfunction

endpackage

/* rtl/gfr_ifs.sv */
// handshake channel interfaces: request, response and rotation write
`timescale 1ns / 1ps

interface gfr_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [7:0]         char_code;
	logic signed [5:0]  base_x;
	logic signed [5:0]  base_y;
	logic signed [5:0]  square_x;
	logic signed [5:0]  square_y;
	logic [4:0]         square_size;
	logic [23:0]        color;
	logic [6:0]         read_index;

	modport source (output valid, op, char_code, base_x, base_y, square_x, square_y,
		square_size, color, read_index, input ready);
	modport sink (input valid, op, char_code, base_x, base_y, square_x, square_y,
		square_size, color, read_index, output ready);
endinterface

interface gfr_rsp_if;
	logic        valid;
	logic        ready;
	logic [23:0] pixel_color;
	logic [7:0]  write_count;

	modport source (output valid, pixel_color, write_count, input ready);
	modport sink (input valid, pixel_color, write_count, output ready);
endinterface

interface gfr_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] rotation;

	modport source (output valid, rotation, input ready);
	modport sink (input valid, rotation, output ready);
endinterface

/* rtl/gfr_ctrl.sv */
// sequencing state machine and response valid of the glyph renderer
`timescale 1ns / 1ps

module gfr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  gfr_pkg::sts_t sts,
	output gfr_pkg::cmd_t cmd
);

	gfr_pkg::state_t state_q, state_d;
	logic            rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gfr_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gfr_pkg::ST_IDLE: begin
				if (req_valid)
					state_d = gfr_pkg::ST_DECODE;
			end
			gfr_pkg::ST_DECODE: begin
				case (sts.op)
					gfr_pkg::OP_CHAR:
						state_d = (sts.kind == gfr_pkg::GLY_NONE) ? gfr_pkg::ST_DONE
							: gfr_pkg::ST_GLYPH;
					gfr_pkg::OP_SQUARE:
						state_d = sts.size_zero ? gfr_pkg::ST_DONE : gfr_pkg::ST_SQUARE;
					gfr_pkg::OP_CLEAR:
						state_d = gfr_pkg::ST_CLEAR;
					default:
						state_d = gfr_pkg::ST_READ;
				endcase
			end
			gfr_pkg::ST_GLYPH, gfr_pkg::ST_SQUARE: begin
				if (sts.last_cell)
					state_d = gfr_pkg::ST_DONE;
			end
			gfr_pkg::ST_CLEAR, gfr_pkg::ST_READ: begin
				state_d = gfr_pkg::ST_DONE;
			end
			gfr_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready)
					state_d = gfr_pkg::ST_IDLE;
			end
			default: begin
				state_d = gfr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready       = (state_q == gfr_pkg::ST_IDLE);
		rsp_valid       = rsp_valid_q;
		cmd.load        = req_valid && (state_q == gfr_pkg::ST_IDLE);
		cmd.glyph_step  = (state_q == gfr_pkg::ST_GLYPH);
		cmd.square_step = (state_q == gfr_pkg::ST_SQUARE);
		cmd.clear       = (state_q == gfr_pkg::ST_CLEAR);
		// result register frees up as the pending one is taken
		cmd.load_out    = (state_q == gfr_pkg::ST_DONE) && (!rsp_valid_q || rsp_ready);
	end

endmodule

/* rtl/gfr_dp.sv */
// datapath: item registers, cell counters, glyph and square address units, framebuffer
`timescale 1ns / 1ps

module gfr_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gfr_pkg::cmd_t                      cmd,
	output gfr_pkg::sts_t                      sts,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_rotation,
	input  logic [1:0]                         op,
	input  logic [7:0]                         char_code,
	input  logic signed [gfr_pkg::COORD_W-1:0] base_x,
	input  logic signed [gfr_pkg::COORD_W-1:0] base_y,
	input  logic signed [gfr_pkg::COORD_W-1:0] square_x,
	input  logic signed [gfr_pkg::COORD_W-1:0] square_y,
	input  logic [gfr_pkg::SIZE_W-1:0]         square_size,
	input  logic [gfr_pkg::COLOR_W-1:0]        color,
	input  logic [gfr_pkg::ADDR_W-1:0]         read_index,
	output logic [gfr_pkg::COLOR_W-1:0]        pixel_color,
	output logic [gfr_pkg::COUNT_W-1:0]        write_count
);

	gfr_pkg::rot_t                      rot_q;
	gfr_pkg::op_t                       op_q;
	gfr_pkg::glyph_kind_t               kind_q, kind_d;
	logic [4:0]                         sym_q, sym_d;
	logic signed [gfr_pkg::COORD_W-1:0] bx_q, by_q, sx_q, sy_q;
	logic [gfr_pkg::SIZE_W-1:0]         size_q;
	logic [gfr_pkg::COLOR_W-1:0]        color_q;
	logic [gfr_pkg::ADDR_W-1:0]         pidx_q;
	logic [4:0]                         inner_q, outer_q, lim_in, lim_out;
	logic [gfr_pkg::COUNT_W-1:0]        count_q;
	logic [gfr_pkg::CELLS-1:0]          vld_q;
	logic [gfr_pkg::COLOR_W-1:0]        mem_q [gfr_pkg::CELLS];
	logic [gfr_pkg::COLOR_W-1:0]        rd_q;
	logic                               rd_vld_q;
	logic [gfr_pkg::COLOR_W-1:0]        pix_out_q;
	logic [gfr_pkg::COUNT_W-1:0]        cnt_out_q;

	logic [2:0]               w_m1, h_m1, r3, c3;
	logic [gfr_pkg::LET_W-1:0] frow;
	logic                     fbit;
	logic [3:0]               gx, gy;
	logic signed [6:0]        gxa, gya;
	logic signed [9:0]        gidx;
	logic                     g_we;
	logic signed [6:0]        sxa, sya;
	logic [6:0]               sx_off, sy_off;
	logic                     s_we;
	logic                     we;
	logic [gfr_pkg::ADDR_W-1:0] waddr;

	// char code to font and symbol index
	always_comb begin
		kind_d = gfr_pkg::GLY_NONE;
		sym_d  = '0;
		if (char_code inside {[8'h30:8'h39]}) begin
			kind_d = gfr_pkg::GLY_DIGIT;
			sym_d  = 5'(char_code - 8'h30);
		end else if (char_code inside {[8'h41:8'h5A]}) begin
			kind_d = gfr_pkg::GLY_LETTER;
			sym_d  = 5'(char_code - 8'h41);
		end else if (char_code inside {[8'h61:8'h7A]}) begin
			kind_d = gfr_pkg::GLY_LETTER;
			sym_d  = 5'(char_code - 8'h61);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= gfr_pkg::ROT_270;
		end else if (cfg_we) begin
			rot_q <= gfr_pkg::rot_t'(cfg_rotation);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= gfr_pkg::op_t'(op);
			kind_q  <= kind_d;
			sym_q   <= sym_d;
			bx_q    <= base_x;
			by_q    <= base_y;
			sx_q    <= square_x;
			sy_q    <= square_y;
			size_q  <= square_size;
			color_q <= color;
			pidx_q  <= read_index;
		end
	end

	// font geometry minus one
	assign w_m1 = (kind_q == gfr_pkg::GLY_DIGIT) ? 3'(gfr_pkg::DIG_W - 1)
		: 3'(gfr_pkg::LET_W - 1);
	assign h_m1 = (kind_q == gfr_pkg::GLY_DIGIT) ? 3'(gfr_pkg::DIG_H - 1)
		: 3'(gfr_pkg::LET_H - 1);

	always_comb begin
		if (op_q == gfr_pkg::OP_SQUARE) begin
			lim_in  = size_q - 5'd1;
			lim_out = size_q - 5'd1;
		end else begin
			lim_in  = {2'b00, w_m1};
			lim_out = {2'b00, h_m1};
		end
	end

	// cell walk: inner runs over columns or dx, outer over rows or dy
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			inner_q <= '0;
			outer_q <= '0;
		end else if (cmd.glyph_step || cmd.square_step) begin
			if (inner_q == lim_in) begin
				inner_q <= '0;
				outer_q <= outer_q + 5'd1;
			end else begin
				inner_q <= inner_q + 5'd1;
			end
		end
	end

	// glyph cell
	assign r3   = outer_q[2:0];
	assign c3   = inner_q[2:0];
	assign frow = gfr_pkg::font_row(kind_q, sym_q, r3);
	assign fbit = frow[w_m1 - c3];

	always_comb begin
		case (rot_q)
			gfr_pkg::ROT_90: begin
				gx = {1'b0, h_m1 - r3};
				gy = {1'b0, c3};
			end
			gfr_pkg::ROT_180: begin
				// keeps the one-column shift of this mode
				gx = {1'b0, w_m1} + 4'd1 - {1'b0, c3};
				gy = {1'b0, h_m1 - r3};
			end
			gfr_pkg::ROT_270: begin
				gx = {1'b0, r3};
				gy = {1'b0, h_m1 - c3};
			end
			default: begin
				gx = {1'b0, c3};
				gy = {1'b0, r3};
			end
		endcase
	end

	assign gxa  = $signed({bx_q[gfr_pkg::COORD_W-1], bx_q}) + $signed({3'b000, gx});
	assign gya  = $signed({by_q[gfr_pkg::COORD_W-1], by_q}) + $signed({3'b000, gy});
	// linear index, so a glyph wraps into the next row
	assign gidx = $signed({gya, 3'b000}) + $signed({{3{gxa[6]}}, gxa});
	assign g_we = fbit && (gidx[9:gfr_pkg::ADDR_W] == '0);

	// square cell, 1-based with the long axis flipped
	assign sxa    = $signed({sx_q[gfr_pkg::COORD_W-1], sx_q}) + $signed({2'b00, inner_q});
	assign sya    = $signed({sy_q[gfr_pkg::COORD_W-1], sy_q}) + $signed({2'b00, outer_q});
	assign sx_off = 7'(gfr_pkg::GRID_H) - sxa;
	assign sy_off = sya - 7'd1;
	assign s_we   = (sxa >= 7'sd1) && (sxa <= 7'(gfr_pkg::GRID_H))
		&& (sya >= 7'sd1) && (sya <= 7'(gfr_pkg::GRID_W));

	assign we    = (cmd.glyph_step && g_we) || (cmd.square_step && s_we);
	assign waddr = cmd.square_step ? {sx_off[gfr_pkg::ROW_W-1:0], sy_off[gfr_pkg::COL_W-1:0]}
		: gidx[gfr_pkg::ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.clear) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			count_q <= '0;
		else if (cmd.clear)
			count_q <= 8'(gfr_pkg::CELLS);
		else if (we)
			count_q <= count_q + 8'd1;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= color_q;
		rd_q     <= mem_q[pidx_q];
		rd_vld_q <= vld_q[pidx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pix_out_q <= (op_q == gfr_pkg::OP_READ && rd_vld_q) ? rd_q : '0;
			cnt_out_q <= count_q;
		end
	end

	assign pixel_color   = pix_out_q;
	assign write_count   = cnt_out_q;
	assign sts.op        = op_q;
	assign sts.kind      = kind_q;
	assign sts.size_zero = (size_q == '0);
	assign sts.last_cell = (inner_q == lim_in) && (outer_q == lim_out);

endmodule

/* rtl/glyph_framebuffer_renderer.sv */
// top level of the glyph framebuffer renderer
`timescale 1ns / 1ps
`include "glyph_framebuffer_renderer_defines.svh"

// Renders characters and squares into a 128-entry, 8 by 16 colour framebuffer and
// reads single pixels back; every request gives one response with the colour read
// (zero except for a read) and the number of entries written. Requests are handled
// one at a time and the framebuffer has a single write port, so drawing goes one
// font or square cell per cycle: a request passes through decode, then its font or
// square cells (a clear or read step instead for a clear or a read, and none for a
// code that draws nothing or a square of size zero), then done. The next request
// is taken while a finished response still waits. The store is empty straight
// after reset and after a clear, with no sweep. Rotation is written through the
// configuration channel, which is always ready; write it only while no request is
// in progress.
module glyph_framebuffer_renderer (
	input  logic      clk,
	input  logic      arst_n,
	gfr_req_if.sink   req,
	gfr_rsp_if.source rsp,
	gfr_cfg_if.sink   cfg
);

	gfr_pkg::cmd_t cmd;
	gfr_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	gfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gfr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg.valid && cfg.ready),
		.cfg_rotation (cfg.rotation),
		.op           (req.op),
		.char_code    (req.char_code),
		.base_x       (req.base_x),
		.base_y       (req.base_y),
		.square_x     (req.square_x),
		.square_y     (req.square_y),
		.square_size  (req.square_size),
		.color        (req.color),
		.read_index   (req.read_index),
		.pixel_color  (rsp.pixel_color),
		.write_count  (rsp.write_count)
	);

	// one request in flight: no second transfer straight after the first
	`GFR_ASSERT_NXT(a_one_in_flight, req.valid && req.ready, !req.ready)
	// a loaded result is offered next cycle
	`GFR_ASSERT_NXT(a_result_offered, cmd.load_out, rsp.valid)
	// no op writes more entries than the store holds
	`GFR_ASSERT_IMP(a_count_bound, rsp.valid, rsp.write_count <= 8'(gfr_pkg::CELLS))

endmodule
